### src/vector_angle_and_length_core_assert.svh
// Assertion macros shared by the vector angle and length core.
`ifndef VECTOR_ANGLE_AND_LENGTH_CORE_ASSERT_SVH
`define VECTOR_ANGLE_AND_LENGTH_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define VAAL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define VAAL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/vaal_pkg.sv
// Shared types and constants of the vector angle and length core.
`timescale 1ns / 1ps
`default_nettype none

package vaal_pkg;

  localparam int ZF        = 20;
  localparam int GUARD     = 24;
  localparam int ITERS     = 27;
  localparam int ZW        = 29;
  localparam int MAG_WIDTH = 16;

  localparam logic [MAG_WIDTH-1:0] MAG_MAX = '1;

  localparam logic [ZW-1:0] DEG90  = 29'd94371840;
  localparam logic [ZW-1:0] DEG180 = 29'd188743680;
  localparam logic [ZW-1:0] DEG360 = 29'd377487360;

  localparam logic [ZW-1:0] ATAN_TAB [ITERS] = '{
    29'd47185920, 29'd27855475, 29'd14718068, 29'd7471121, 29'd3750058,
    29'd1876857,  29'd938658,   29'd469357,   29'd234682,  29'd117342,
    29'd58671,    29'd29335,    29'd14668,    29'd7334,    29'd3667,
    29'd1833,     29'd917,      29'd458,      29'd229,     29'd115,
    29'd57,       29'd29,       29'd14,       29'd7,       29'd4,
    29'd2,        29'd1
  };

  typedef struct packed {
    logic xn;
    logic yn;
    logic x_zero;
    logic y_zero;
    logic zero;
  } vaal_quad_t;

endpackage

`default_nettype wire

### src/vaal_cordic.sv
// Pipelined CORDIC vectoring unit: one iteration per stage, stages past ITERS pass through.
`timescale 1ns / 1ps
`default_nettype none

module vaal_cordic
  import vaal_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int STAGES      = 27
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ce,
  input  logic                   valid,
  input  vaal_quad_t             quad,
  input  logic [COORD_WIDTH-1:0] ax,
  input  logic [COORD_WIDTH-1:0] ay,
  output logic                   res_valid,
  output vaal_quad_t             res_quad,
  output logic signed [ZW-1:0]   res_z
);

  localparam int DW = COORD_WIDTH + GUARD + 3;

  logic                 vld  [STAGES];
  vaal_quad_t           qd   [STAGES];
  logic signed [DW-1:0] cx   [STAGES];
  logic signed [DW-1:0] cy   [STAGES];
  logic signed [ZW-1:0] z    [STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    logic                 pv;
    vaal_quad_t           pq;
    logic signed [DW-1:0] px, py, nx, ny;
    logic signed [ZW-1:0] pz, nz;

    if (j == 0) begin : g_first
      assign pv = valid;
      assign pq = quad;
      assign px = $signed(DW'({ax, {GUARD{1'b0}}}));
      assign py = $signed(DW'({ay, {GUARD{1'b0}}}));
      assign pz = '0;
    end else begin : g_next
      assign pv = vld[j-1];
      assign pq = qd[j-1];
      assign px = cx[j-1];
      assign py = cy[j-1];
      assign pz = z[j-1];
    end

    if (j < ITERS) begin : g_iter
      always_comb begin
        if (!py[DW-1]) begin
          nx = px + (py >>> j);
          ny = py - (px >>> j);
          nz = pz + $signed(ATAN_TAB[j]);
        end else begin
          nx = px - (py >>> j);
          ny = py + (px >>> j);
          nz = pz - $signed(ATAN_TAB[j]);
        end
      end
    end else begin : g_pass
      assign nx = px;
      assign ny = py;
      assign nz = pz;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (ce) begin
        vld[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        qd[j] <= pq;
        cx[j] <= nx;
        cy[j] <= ny;
        z[j]  <= nz;
      end
    end
  end

  assign res_valid = vld[STAGES-1];
  assign res_quad  = qd[STAGES-1];
  assign res_z     = z[STAGES-1];

endmodule

`default_nettype wire

### src/vaal_sqrt.sv
// Pipelined squares, sum and digit-by-digit rounded square root.
`timescale 1ns / 1ps
`default_nettype none

module vaal_sqrt
  import vaal_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int STAGES      = 27
) (
  input  logic                   clk,
  input  logic                   ce,
  input  logic [COORD_WIDTH-1:0] ax,
  input  logic [COORD_WIDTH-1:0] ay,
  output logic [MAG_WIDTH-1:0]   mag
);

  localparam int SW = 2 * COORD_WIDTH;

  logic [SW-1:0] rem  [STAGES];
  logic [SW-1:0] root [STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    if (j == 0) begin : g_square
      always_ff @(posedge clk) begin
        if (ce) begin
          rem[j]  <= SW'(ax) * SW'(ax);
          root[j] <= SW'(ay) * SW'(ay);
        end
      end
    end else if (j == 1) begin : g_sum
      always_ff @(posedge clk) begin
        if (ce) begin
          rem[j]  <= rem[j-1] + root[j-1];
          root[j] <= '0;
        end
      end
    end else if (j <= COORD_WIDTH + 1) begin : g_digit
      localparam int B = 2 * (COORD_WIDTH + 1 - j);
      localparam logic [SW:0] STEP = {{SW{1'b0}}, 1'b1} << B;
      logic [SW:0] trial;
      assign trial = {1'b0, root[j-1]} + STEP;
      always_ff @(posedge clk) begin
        if (ce) begin
          if ({1'b0, rem[j-1]} >= trial) begin
            rem[j]  <= rem[j-1] - trial[SW-1:0];
            root[j] <= (root[j-1] >> 1) + STEP[SW-1:0];
          end else begin
            rem[j]  <= rem[j-1];
            root[j] <= root[j-1] >> 1;
          end
        end
      end
    end else if (j == COORD_WIDTH + 2) begin : g_round
      logic [SW-1:0] rnd;
      assign rnd = root[j-1] + SW'(rem[j-1] > root[j-1]);
      always_ff @(posedge clk) begin
        if (ce) begin
          rem[j]  <= '0;
          root[j] <= (rnd > SW'(MAG_MAX)) ? SW'(MAG_MAX) : rnd;
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (ce) begin
          rem[j]  <= rem[j-1];
          root[j] <= root[j-1];
        end
      end
    end
  end

  assign mag = root[STAGES-1][MAG_WIDTH-1:0];

endmodule

`default_nettype wire

### src/vaal_post.sv
// Quadrant fix-up, rounding and full-turn wrap of the angle.
`timescale 1ns / 1ps
`default_nettype none

module vaal_post
  import vaal_pkg::*;
#(
  parameter int ANGLE_FRACTION_BITS = 6,
  parameter int ANGLE_WIDTH         = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ce,
  input  logic                   valid,
  input  vaal_quad_t             quad,
  input  logic signed [ZW-1:0]   z,
  input  logic [MAG_WIDTH-1:0]   mag,
  output logic                   res_valid,
  output logic [ANGLE_WIDTH-1:0] res_angle,
  output logic [MAG_WIDTH-1:0]   res_mag,
  output logic                   res_zero
);

  localparam int SH = ZF - ANGLE_FRACTION_BITS;
  localparam int KW = ZW + 1 - SH;
  localparam logic [ZW:0]   RND  = {{ZW{1'b0}}, 1'b1} << (SH - 1);
  localparam logic [KW-1:0] FULL = KW'(360) << ANGLE_FRACTION_BITS;

  logic [ZW-1:0]        zc, t, a;
  logic                 v1;
  logic [ZW-1:0]        a1;
  logic [MAG_WIDTH-1:0] mag1;
  logic                 zero1;
  logic [ZW:0]          ksum;
  logic [KW-1:0]        k, kw;

  always_comb begin
    if (z[ZW-1]) begin
      zc = '0;
    end else if (z > $signed(DEG90)) begin
      zc = DEG90;
    end else begin
      zc = $unsigned(z);
    end

    if (quad.y_zero) begin
      t = '0;
    end else if (quad.x_zero) begin
      t = DEG90;
    end else begin
      t = zc;
    end

    if (!quad.xn && !quad.yn && !quad.y_zero) begin
      a = t;
    end else if (quad.y_zero && !quad.xn) begin
      a = '0;
    end else if (quad.xn && !quad.yn) begin
      a = DEG180 - t;
    end else if (quad.xn && quad.yn) begin
      a = DEG180 + t;
    end else begin
      a = DEG360 - t;
    end
  end

  assign ksum = {1'b0, a1} + RND;
  assign k    = ksum[ZW:SH];
  assign kw   = (k >= FULL) ? (k - FULL) : k;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      res_valid <= 1'b0;
    end else if (ce) begin
      v1        <= valid;
      res_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a1        <= a;
      mag1      <= mag;
      zero1     <= quad.zero;
      res_angle <= kw[ANGLE_WIDTH-1:0];
      res_mag   <= mag1;
      res_zero  <= zero1;
    end
  end

endmodule

`default_nettype wire

### src/vector_angle_and_length_core.sv
// Top level of the vector angle and length core: input stage, pipelines, output buffer.
// Takes one signed 2D vector per transfer and returns its direction angle (counter-clockwise
// from +x, in 2^-ANGLE_FRACTION_BITS degree, 0 up to one full turn exclusive) and its
// rounded Euclidean length, saturating at 65535; a zero vector raises tuser with angle and
// length 0. One vector is taken every cycle while the output buffer has room (s_tready).
// The CORDIC iterations take 27 stages and the square-root digit pipeline beside them
// COORD_WIDTH + 3, the shorter padded with pass stages; both share one input register,
// two fix-up stages and the output register. A two-entry output buffer keeps s_tready
// high while one result waits on m_tready.
`timescale 1ns / 1ps
`default_nettype none

`include "vector_angle_and_length_core_assert.svh"

module vector_angle_and_length_core
  import vaal_pkg::*;
#(
  parameter int COORD_WIDTH         = 16,
  parameter int ANGLE_FRACTION_BITS = 6,
  localparam int ANGLE_WIDTH = $clog2(360 << ANGLE_FRACTION_BITS),
  localparam int IN_W        = ((2 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W       = ((ANGLE_WIDTH + MAG_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // x_coord, y_coord
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // angle, magnitude
  output logic [0:0]       m_tuser    // zero_vector
);

  localparam int NSTG = (ITERS > COORD_WIDTH + 3) ? ITERS : COORD_WIDTH + 3;
  localparam logic [ANGLE_WIDTH-1:0] FULL_TURN = ANGLE_WIDTH'(360 << ANGLE_FRACTION_BITS);

  logic                   ce;
  logic [COORD_WIDTH-1:0] x_raw, y_raw;
  logic                   fvalid;
  vaal_quad_t             fquad;
  logic [COORD_WIDTH-1:0] fax, fay;

  logic                   cvalid;
  vaal_quad_t             cquad;
  logic signed [ZW-1:0]   cz;
  logic [MAG_WIDTH-1:0]   smag;

  logic                   pvalid;
  logic [ANGLE_WIDTH-1:0] pangle;
  logic [MAG_WIDTH-1:0]   pmag;
  logic                   pzero;
  logic [OUT_W-1:0]       pdata;

  logic                   skid_valid;
  logic [OUT_W-1:0]       skid_data;
  logic                   skid_user;

  assign ce       = !skid_valid;
  assign s_tready = ce;

  assign x_raw = s_tdata[COORD_WIDTH-1:0];
  assign y_raw = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (ce) begin
      fvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fax          <= x_raw[COORD_WIDTH-1] ? (~x_raw + COORD_WIDTH'(1)) : x_raw;
      fay          <= y_raw[COORD_WIDTH-1] ? (~y_raw + COORD_WIDTH'(1)) : y_raw;
      fquad.xn     <= x_raw[COORD_WIDTH-1];
      fquad.yn     <= y_raw[COORD_WIDTH-1];
      fquad.x_zero <= (x_raw == '0);
      fquad.y_zero <= (y_raw == '0);
      fquad.zero   <= (x_raw == '0) && (y_raw == '0);
    end
  end

  vaal_cordic #(
    .COORD_WIDTH (COORD_WIDTH),
    .STAGES      (NSTG)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .valid     (fvalid),
    .quad      (fquad),
    .ax        (fax),
    .ay        (fay),
    .res_valid (cvalid),
    .res_quad  (cquad),
    .res_z     (cz)
  );

  vaal_sqrt #(
    .COORD_WIDTH (COORD_WIDTH),
    .STAGES      (NSTG)
  ) u_sqrt (
    .clk (clk),
    .ce  (ce),
    .ax  (fax),
    .ay  (fay),
    .mag (smag)
  );

  vaal_post #(
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS),
    .ANGLE_WIDTH         (ANGLE_WIDTH)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .valid     (cvalid),
    .quad      (cquad),
    .z         (cz),
    .mag       (smag),
    .res_valid (pvalid),
    .res_angle (pangle),
    .res_mag   (pmag),
    .res_zero  (pzero)
  );

  assign pdata = OUT_W'({pmag, pangle});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= pvalid && ce;
      end
    end else if (pvalid && ce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tdata    <= skid_data;
        m_tuser[0] <= skid_user;
      end else begin
        m_tdata    <= pdata;
        m_tuser[0] <= pzero;
      end
    end else if (pvalid && ce) begin
      skid_data <= pdata;
      skid_user <= pzero;
    end
  end

  `VAAL_ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, m_tvalid,
                     "skid full with output empty")
  `VAAL_ASSERT_NEXT(a_stall_to_skid, clk, rst, pvalid && ce && m_tvalid && !m_tready,
                    skid_valid, "stalled result not held in skid")
  `VAAL_ASSERT_IMPLY(a_zero_clear, clk, rst, m_tvalid && m_tuser[0], m_tdata == '0,
                     "zero vector with nonzero angle or length")
  `VAAL_ASSERT_IMPLY(a_angle_range, clk, rst, m_tvalid,
                     m_tdata[ANGLE_WIDTH-1:0] < FULL_TURN, "angle at or beyond full turn")

endmodule

`default_nettype wire

### verif/vaal_checker.sv
// Scoreboard for the vector angle and length core: predicts each result and compares it.
`timescale 1ns / 1ps

module vaal_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // x_coord, y_coord
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // angle, magnitude
  input  logic [0:0]  m_tuser,   // zero_vector
  output int          fail_count,
  output int          pending
);

  localparam int TURN_FRAC    = 20;
  localparam int OUT_FRAC     = 6;
  localparam int CORDIC_STEPS = 27;
  localparam int GUARD_SHIFT  = 24;
  localparam longint HALF_TURN_DEG = 180;
  localparam longint FULL_TURN_DEG = 360;
  localparam longint QUARTER_ANGLE = longint'(90) <<< TURN_FRAC;
  localparam longint HALF_ANGLE    = HALF_TURN_DEG <<< TURN_FRAC;
  localparam longint FULL_ANGLE    = FULL_TURN_DEG <<< TURN_FRAC;
  localparam longint FULL_CODES    = FULL_TURN_DEG <<< OUT_FRAC;
  localparam longint LENGTH_LIMIT  = 65535;

  // atan(2^-i) in degrees scaled by 2^20
  localparam longint ARCTAN_STEP [CORDIC_STEPS] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
    469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  typedef struct {
    logic signed [15:0] x_in;
    logic signed [15:0] y_in;
    logic [14:0]        angle;
    logic [15:0]        magnitude;
    logic               zero_vector;
  } polar_result_t;

  polar_result_t expected_polar_q [$];
  int mismatch_count = 0;

  assign fail_count = mismatch_count;
  initial pending = 0;

  function automatic longint rounded_length(longint unsigned sum_sq);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = sum_sq;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    if (rem > root) root++;
    if (root > LENGTH_LIMIT) root = LENGTH_LIMIT;
    return longint'(root);
  endfunction

  function automatic longint first_quadrant_angle(longint ax, longint ay);
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    longint z;
    int i;
    cx = ax <<< GUARD_SHIFT;
    cy = ay <<< GUARD_SHIFT;
    z  = 0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        z  = z + ARCTAN_STEP[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        z  = z - ARCTAN_STEP[i];
      end
    end
    if (z < 0) z = 0;
    if (z > QUARTER_ANGLE) z = QUARTER_ANGLE;
    return z;
  endfunction

  function automatic polar_result_t predict_direction_and_length(logic signed [15:0] x,
                                                                 logic signed [15:0] y);
    polar_result_t res;
    longint xs;
    longint ys;
    longint ax;
    longint ay;
    longint t;
    longint a;
    longint codes;
    xs = x;
    ys = y;
    ax = (xs < 0) ? -xs : xs;
    ay = (ys < 0) ? -ys : ys;
    res.x_in = x;
    res.y_in = y;
    if (ax == 0 && ay == 0) begin
      res.angle       = '0;
      res.magnitude   = '0;
      res.zero_vector = 1'b1;
      return res;
    end
    res.magnitude = 16'(rounded_length(longint'(ax * ax + ay * ay)));
    if (ay == 0) t = 0;
    else if (ax == 0) t = QUARTER_ANGLE;
    else t = first_quadrant_angle(ax, ay);
    if (xs >= 0 && ys >= 0 && ay != 0) a = t;
    else if (ay == 0 && xs >= 0) a = 0;
    else if (xs < 0 && ys >= 0) a = HALF_ANGLE - t;
    else if (xs < 0 && ys < 0) a = HALF_ANGLE + t;
    else a = FULL_ANGLE - t;
    codes = (a + (longint'(1) <<< (TURN_FRAC - OUT_FRAC - 1))) >>> (TURN_FRAC - OUT_FRAC);
    if (codes >= FULL_CODES) codes = codes - FULL_CODES;
    res.angle       = 15'(codes);
    res.zero_vector = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    polar_result_t exp_res;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_polar_q.push_back(predict_direction_and_length(s_tdata[15:0], s_tdata[31:16]));
      end
      if (m_tvalid && m_tready) begin
        if (expected_polar_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected transfer: angle=%0d magnitude=%0d zero_vector=%0b",
                     m_tdata[14:0], m_tdata[30:15], m_tuser[0]);
          end
        end else begin
          exp_res = expected_polar_q.pop_front();
          if (m_tdata[14:0] !== exp_res.angle || m_tdata[30:15] !== exp_res.magnitude ||
              m_tuser[0] !== exp_res.zero_vector) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch x=%0d y=%0d: angle %0d/%0d magnitude %0d/%0d zero %0b/%0b",
                       exp_res.x_in, exp_res.y_in, exp_res.angle, m_tdata[14:0],
                       exp_res.magnitude, m_tdata[30:15], exp_res.zero_vector, m_tuser[0]);
            end
          end
        end
      end
      pending <= expected_polar_q.size();
    end
  end

endmodule

### verif/tb_top.sv
// Testbench top for the vector angle and length core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // x_coord, y_coord
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // angle, magnitude
  logic [0:0]  m_tuser;        // zero_vector
  int          fail_count;
  int          pending;
  int          calm_items = 0;

  vector_angle_and_length_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  vaal_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_extreme();
    logic [15:0] corner [7] = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001,
                                16'h7FFE, 16'h7FFF};
    return corner[$urandom_range(0, 6)];
  endfunction

  function automatic logic [15:0] pick_small(int span);
    int v;
    v = $urandom_range(0, 2 * span) - span;
    return v[15:0];
  endfunction

  task automatic send_vector(input logic [15:0] x, input logic [15:0] y);
    int gap;
    if (calm_items > 0) begin
      calm_items--;
      gap = 0;
    end else begin
      gap = idle_cycles();
      if ($urandom_range(0, 63) == 0) calm_items = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random_vector();
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] mag;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      4: begin
        x = pick_small(4);
        y = pick_small(4);
      end
      5: begin
        if ($urandom_range(0, 1)) begin
          x = 16'($urandom);
          y = pick_small(2);
        end else begin
          x = pick_small(2);
          y = 16'($urandom);
        end
      end
      6: begin
        x = pick_extreme();
        y = pick_extreme();
      end
      7: begin
        mag = 16'($urandom_range(1, 32767));
        x = $urandom_range(0, 1) ? -mag : mag;
        y = $urandom_range(0, 1) ? -mag : mag;
      end
      8: begin
        x = 16'($signed(16'($urandom)) >>> $urandom_range(0, 15));
        y = 16'($signed(16'($urandom)) >>> $urandom_range(0, 15));
      end
      default: begin
        x = $urandom_range(0, 2) == 0 ? 16'h0000 : 16'($urandom);
        y = x == 16'h0000 ? 16'($urandom) & {16{$urandom_range(0, 1) == 1'b1}} : 16'h0000;
      end
    endcase
    send_vector(x, y);
  endtask

  initial begin
    int hold;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 15) == 0) hold = 0;
      else hold = idle_cycles();
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      if ($urandom_range(0, 31) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    #6ms;
    $display("FAIL vector_angle_and_length_core");
    $finish;
  end

  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero vector, axes, corners, quadrants and the wrap just below a full turn
    send_vector(16'h0000, 16'h0000);
    send_vector(16'h0001, 16'h0000);
    send_vector(16'h7FFF, 16'h0000);
    send_vector(16'hFFFF, 16'h0000);
    send_vector(16'h8000, 16'h0000);
    send_vector(16'h0000, 16'h0001);
    send_vector(16'h0000, 16'h7FFF);
    send_vector(16'h0000, 16'hFFFF);
    send_vector(16'h0000, 16'h8000);
    send_vector(16'h7FFF, 16'h7FFF);
    send_vector(16'h8000, 16'h8000);
    send_vector(16'h8000, 16'h7FFF);
    send_vector(16'h7FFF, 16'h8000);
    send_vector(16'h0001, 16'h0001);
    send_vector(16'hFFFF, 16'h0001);
    send_vector(16'hFFFF, 16'hFFFF);
    send_vector(16'h0001, 16'hFFFF);
    send_vector(16'h7FFF, 16'hFFFF);
    send_vector(16'h8000, 16'hFFFF);
    send_vector(16'h8000, 16'h0001);
    send_vector(16'h7FFF, 16'h0001);
    send_vector(16'h0003, 16'h0004);
    send_vector(16'hAAAA, 16'h5555);
    send_vector(16'h5555, 16'hAAAA);

    for (n = 0; n < 1400; n++) send_random_vector();
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS vector_angle_and_length_core");
    end else begin
      $display("FAIL vector_angle_and_length_core");
    end
    $finish;
  end

endmodule
